/* hdl/itoaf_pkg.sv */
// Shared types, character codes and the hex digit-to-ASCII mapping
// for the integer-to-ASCII formatter. No dependencies.
`timescale 1ns / 1ps

package itoaf_pkg;

	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned WORK_W     = 33;
	localparam int unsigned CHAR_W     = 7;

	// Ten BCD or hex digits; index 9 is the most significant.
	typedef logic [NUM_DIGITS-1:0][3:0] digits_t;
	typedef logic [WORK_W-1:0]          work_t;
	typedef logic [CHAR_W-1:0]          char_t;

	typedef enum logic [1:0] {
		CMD_HEX  = 2'd0,
		CMD_UDEC = 2'd1,
		CMD_SDEC = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	localparam char_t CHAR_ZERO  = 7'h30;
	localparam char_t CHAR_UPPER = 7'h41;
	localparam char_t CHAR_MINUS = 7'h2D;
	localparam char_t CHAR_X     = 7'h78;

	function automatic char_t hex_char(input logic [3:0] d);
		char_t c;
		if (d > 4'd9) begin
			c = CHAR_UPPER + char_t'(d) - char_t'(10);
		end else begin
			c = CHAR_ZERO + char_t'(d);
		end
		return c;
	endfunction

endpackage

/* hdl/itoaf_bcd_step.sv */
// One double-dabble step: add-3 correction on every BCD digit, then shift
// the digit vector and the binary work word left by one. Uses itoaf_pkg.
`timescale 1ns / 1ps

module itoaf_bcd_step import itoaf_pkg::*; (
	input  digits_t d_in,
	input  work_t   w_in,
	output digits_t d_out,
	output work_t   w_out
);

	digits_t adj;

	always_comb begin
		for (int k = 0; k < NUM_DIGITS; k++) begin
			adj[k] = (d_in[k] >= 4'd5) ? (d_in[k] + 4'd3) : d_in[k];
		end
	end

	// Shift the binary MSB into the least significant BCD digit.
	assign {d_out, w_out} = {adj[NUM_DIGITS-1:0], w_in} << 1;

endmodule

/* hdl/integer_to_ascii_formatter_unit.sv */
// Integer-to-ASCII formatter: one number in, a run of ASCII characters out.
// Hex: an accept step, the two prefix characters when asked, a skip step per dropped
// leading zero plus one to leave, then one character per digit.
// Decimal: an accept step, the double-dabble steps on the shared BCD step unit, a sign
// character for negatives, skip steps as for hex, then one character per digit.
// One number at a time: in_ready is high only while the sequencer is idle, and output
// stalls hold it. arst_n clears state, count, position and output valid only.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_unit import itoaf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] value,
	input  logic [3:0]  min_digits,
	input  logic        add_prefix,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  ascii_char,
	output logic        last
);

	localparam logic [5:0] BCD_STEPS = 6'(WORK_W);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DABBLE = 6'b000010,
		ST_PFX0   = 6'b000100,
		ST_PFX1   = 6'b001000,
		ST_SKIP   = 6'b010000,
		ST_DIGIT  = 6'b100000
	} state_t;

	state_t      state_q, state_d;
	digits_t     digits_q, digits_d;
	work_t       work_q, work_d;
	logic [5:0]  cnt_q, cnt_d;
	logic [3:0]  pos_q, pos_d;
	logic [3:0]  min_q, min_d;
	logic        neg_q, neg_d;
	logic        out_valid_q, out_valid_d;
	char_t       char_q, char_d;
	logic        last_q, last_d;

	logic        out_free;
	logic        load_out;
	logic [3:0]  cur_digit;
	logic [3:0]  hex_min;
	work_t       mag;
	logic        is_neg;
	digits_t     step_digits;
	work_t       step_work;

	// Shared arithmetic unit: one BCD correct-and-shift per cycle.
	itoaf_bcd_step u_step (
		.d_in  (digits_q),
		.w_in  (work_q),
		.d_out (step_digits),
		.w_out (step_work)
	);

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign ascii_char = char_q;
	assign last       = last_q;

	// Output register takes a new character when empty or being drained.
	assign out_free  = !out_valid_q || out_ready;
	assign cur_digit = digits_q[pos_q];

	// Hex minimum: zero counts as one, anything above eight saturates.
	always_comb begin
		if (min_digits == 4'd0) begin
			hex_min = 4'd1;
		end else if (min_digits > 4'd8) begin
			hex_min = 4'd8;
		end else begin
			hex_min = min_digits;
		end
	end

	// Signed mode takes the magnitude in 33 bits so the most negative value fits.
	assign is_neg = (cmd == CMD_SDEC) && value[31];
	assign mag    = is_neg ? (work_t'(33'h1_0000_0000) - {1'b0, value}) : {1'b0, value};

	always_comb begin
		state_d  = state_q;
		digits_d = digits_q;
		work_d   = work_q;
		cnt_d    = cnt_q;
		pos_d    = pos_q;
		min_d    = min_q;
		neg_d    = neg_q;
		char_d   = char_q;
		last_d   = last_q;
		load_out = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (cmd)
						CMD_HEX: begin
							// Hex digits sit directly in the low eight slots.
							digits_d = {8'h00, value};
							pos_d    = 4'd7;
							min_d    = hex_min;
							neg_d    = 1'b0;
							state_d  = add_prefix ? ST_PFX0 : ST_SKIP;
						end
						CMD_UDEC, CMD_SDEC: begin
							digits_d = '0;
							work_d   = mag;
							cnt_d    = BCD_STEPS;
							pos_d    = 4'd9;
							min_d    = 4'd1;
							neg_d    = is_neg;
							state_d  = ST_DABBLE;
						end
						default: begin
							// Mode three: drop the transfer, emit nothing.
						end
					endcase
				end
			end
			ST_DABBLE: begin
				digits_d = step_digits;
				work_d   = step_work;
				cnt_d    = cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					state_d = neg_q ? ST_PFX0 : ST_SKIP;
				end
			end
			ST_PFX0: begin
				// First lead-in character: '-' for negatives, else '0' of "0x".
				if (out_free) begin
					load_out = 1'b1;
					char_d   = neg_q ? CHAR_MINUS : CHAR_ZERO;
					last_d   = 1'b0;
					state_d  = neg_q ? ST_SKIP : ST_PFX1;
				end
			end
			ST_PFX1: begin
				if (out_free) begin
					load_out = 1'b1;
					char_d   = CHAR_X;
					last_d   = 1'b0;
					state_d  = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// Drop leading zeros until only the minimum digit count remains.
				if ((cur_digit == 4'd0) && (pos_q >= min_q)) begin
					pos_d = pos_q - 4'd1;
				end else begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (out_free) begin
					load_out = 1'b1;
					char_d   = hex_char(cur_digit);
					last_d   = (pos_q == 4'd0);
					if (pos_q == 4'd0) begin
						state_d = ST_IDLE;
					end else begin
						pos_d = pos_q - 4'd1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the character until the transfer completes.
	always_comb begin
		if (load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			pos_q       <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			cnt_q       <= cnt_d;
			pos_q       <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		digits_q <= digits_d;
		work_q   <= work_d;
		min_q    <= min_d;
		neg_q    <= neg_d;
		char_q   <= char_d;
		last_q   <= last_d;
	end

endmodule
